[rtl/pmd_pkg.sv]
// Shared types, register map and arithmetic constants of the PID derivative-on-measurement core.
package pmd_pkg;

	localparam int GAIN_FRAC_BITS = 8;
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int SUM_W = 24;
	localparam int ERR_W = 17;
	localparam int ACC_W = 42;
	localparam int OFS_W = 18;

	typedef enum logic [2:0] {
		REG_KP = 3'd0,
		REG_KI = 3'd1,
		REG_KD = 3'd2,
		REG_OUT_OFFSET = 3'd3,
		REG_UPPER_LIMIT = 3'd4,
		REG_LOWER_LIMIT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] kp;
		logic signed [15:0] ki;
		logic signed [15:0] kd;
		logic [14:0] out_offset;
		logic signed [15:0] upper_limit;
		logic signed [15:0] lower_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] error_sum;
		logic signed [15:0] prev_measured;
	} state_t;

endpackage

[rtl/pmd_cfg_regs.sv]
// APB configuration register file holding gains, offset and drive limits.
module pmd_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pmd_pkg::CFG_AW-1:0] paddr,
	input  logic [pmd_pkg::CFG_DW-1:0] pwdata,
	output logic [pmd_pkg::CFG_DW-1:0] prdata,
	output logic pready,
	output pmd_pkg::cfg_t cfg
);
	import pmd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp <= '0;
			cfg_q.ki <= '0;
			cfg_q.kd <= '0;
			cfg_q.out_offset <= '0;
			cfg_q.upper_limit <= 16'sh7fff;
			cfg_q.lower_limit <= 16'sh8000;
		end else if (wr_en) begin
			unique case (idx)
				REG_KP: cfg_q.kp <= pwdata[15:0];
				REG_KI: cfg_q.ki <= pwdata[15:0];
				REG_KD: cfg_q.kd <= pwdata[15:0];
				REG_OUT_OFFSET: cfg_q.out_offset <= pwdata[14:0];
				REG_UPPER_LIMIT: cfg_q.upper_limit <= pwdata[15:0];
				REG_LOWER_LIMIT: cfg_q.lower_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP: prdata = {{16{cfg_q.kp[15]}}, cfg_q.kp};
			REG_KI: prdata = {{16{cfg_q.ki[15]}}, cfg_q.ki};
			REG_KD: prdata = {{16{cfg_q.kd[15]}}, cfg_q.kd};
			REG_OUT_OFFSET: prdata = {17'd0, cfg_q.out_offset};
			REG_UPPER_LIMIT: prdata = {{16{cfg_q.upper_limit[15]}}, cfg_q.upper_limit};
			REG_LOWER_LIMIT: prdata = {{16{cfg_q.lower_limit[15]}}, cfg_q.lower_limit};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/pmd_datapath.sv]
// Single-pass control law: integral update, three gain products, saturation, offset and limits.
module pmd_datapath (
	input  pmd_pkg::cfg_t cfg,
	input  pmd_pkg::state_t state,
	input  logic mode,
	input  logic signed [15:0] target,
	input  logic signed [15:0] measured,
	output pmd_pkg::state_t state_nxt,
	output logic signed [15:0] drive,
	output logic limited
);
	import pmd_pkg::*;

	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] dmeas;
	logic signed [SUM_W:0] sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [32:0] prod_p;
	logic signed [39:0] prod_i;
	logic signed [32:0] prod_d;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [15:0] drive16;
	logic sat_hit;
	logic signed [OFS_W-1:0] ofs;
	logic signed [OFS_W-1:0] up_ext;
	logic signed [OFS_W-1:0] lo_ext;
	logic signed [OFS_W-1:0] clamped;
	logic lim_hit;

	assign err = ERR_W'(target) - ERR_W'(measured);
	assign dmeas = ERR_W'(measured) - ERR_W'(state.prev_measured);

	// Saturating integral; an overflow shows as the two top bits differing.
	assign sum_wide = (SUM_W+1)'(state.error_sum) + (SUM_W+1)'(err);
	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_wide[SUM_W-1:0];
	end

	always_comb begin
		state_nxt.prev_measured = mode ? state.prev_measured : measured;
		if (mode || cfg.ki == '0)
			state_nxt.error_sum = '0;
		else
			state_nxt.error_sum = sum_sat;
	end

	assign prod_p = 33'(cfg.kp) * 33'(err);
	assign prod_i = 40'(cfg.ki) * 40'(state_nxt.error_sum);
	assign prod_d = 33'(cfg.kd) * 33'(dmeas);
	assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) - ACC_W'(prod_d);
	assign acc_sh = acc >>> GAIN_FRAC_BITS;

	// Fits 16 bits only when bit 15 and all bits above it equal the sign.
	always_comb begin
		sat_hit = (acc_sh[ACC_W-1:15] != {(ACC_W-15){acc_sh[ACC_W-1]}});
		if (sat_hit)
			drive16 = acc_sh[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
		else
			drive16 = acc_sh[15:0];
	end

	always_comb begin
		if (drive16 > 16'sd0)
			ofs = OFS_W'(drive16) + OFS_W'({3'b000, cfg.out_offset});
		else if (drive16 < 16'sd0)
			ofs = OFS_W'(drive16) - OFS_W'({3'b000, cfg.out_offset});
		else
			ofs = '0;
	end

	assign up_ext = OFS_W'(cfg.upper_limit);
	assign lo_ext = OFS_W'(cfg.lower_limit);

	// Upper clamp first, then lower, so crossed limits resolve to the lower one.
	always_comb begin
		clamped = ofs;
		lim_hit = 1'b0;
		if (clamped > up_ext) begin
			clamped = up_ext;
			lim_hit = 1'b1;
		end
		if (clamped < lo_ext) begin
			clamped = lo_ext;
			lim_hit = 1'b1;
		end
	end

	always_comb begin
		if (mode) begin
			drive = '0;
			limited = 1'b0;
		end else begin
			drive = clamped[15:0];
			limited = sat_hit || lim_hit;
		end
	end

endmodule

[rtl/pid_measurement_derivative_core.sv]
// PID core with derivative on measurement: one word per control tick.
// An accepted word is held in the input register; its result then goes to the output register.
// One word per cycle while the output is not stalled; the gain products and clamps sit
// between the input register and the result register, and the integral state updates as
// each word passes. Reset clears the pipeline, the integral and previous measurement, and
// sets the registers to their default gains and limits.
module pid_measurement_derivative_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic signed [15:0] target,
	input  logic signed [15:0] measured,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] drive,
	output logic limited,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pmd_pkg::CFG_AW-1:0] paddr,
	input  logic [pmd_pkg::CFG_DW-1:0] pwdata,
	output logic [pmd_pkg::CFG_DW-1:0] prdata,
	output logic pready
);
	import pmd_pkg::*;

	cfg_t cfg;
	state_t state_q;
	state_t state_nxt;
	logic valid_s1;
	logic mode_s1;
	logic signed [15:0] target_s1;
	logic signed [15:0] measured_s1;
	logic out_valid_q;
	logic signed [15:0] drive_q;
	logic limited_q;
	logic signed [15:0] drive_c;
	logic limited_c;
	logic advance;

	pmd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	pmd_datapath u_dp (
		.cfg(cfg),
		.state(state_q),
		.mode(mode_s1),
		.target(target_s1),
		.measured(measured_s1),
		.state_nxt(state_nxt),
		.drive(drive_c),
		.limited(limited_c)
	);

	// The input stage moves on whenever the result register is empty or being emptied.
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			target_s1 <= target;
			measured_s1 <= measured;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q <= drive_c;
			limited_q <= limited_c;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign limited = limited_q;

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && mode_s1) |=> (drive == 16'sd0 && !limited && state_q.error_sum == '0))
		else $error("clear word did not zero integral and drive");

	a_ki_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && cfg.ki == '0) |=> (state_q.error_sum == '0))
		else $error("integral kept with zero integral gain");

	a_prev_meas: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && !mode_s1) |=> (state_q.prev_measured == $past(measured_s1)))
		else $error("previous measurement not updated");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(state_q))
		else $error("state changed without a word passing");

endmodule

[bench/pid_measurement_derivative_core_test.sv]
// Self-checking testbench for the PID derivative-on-measurement core, with a tick-level predictor.
module pid_measurement_derivative_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pmd_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam longint SUM_HI = 64'sd8388607;
	localparam longint SUM_LO = -64'sd8388608;

	typedef struct {
		logic signed [15:0] drive;
		logic limited;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic signed [15:0] target = '0;
	logic signed [15:0] measured = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] drive;
	logic limited;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	// Shadow copy of the register file and of the controller state.
	cfg_t gains;
	logic signed [SUM_W-1:0] integ_sum;
	logic signed [15:0] last_measured;

	tick_result_t pending_drives[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int ready_mode = 0;
	int ready_count = 0;

	pid_measurement_derivative_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.target(target),
		.measured(measured),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.limited(limited),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// One control tick: integral update, gain products, floor shift, saturation,
	// offset away from zero and the two limit clamps.
	function automatic void predict_tick(input logic clr, input logic signed [15:0] tgt,
		input logic signed [15:0] meas, output tick_result_t res);
		longint err;
		longint sum;
		longint acc;
		res.limited = 1'b0;
		res.drive = '0;
		if (clr) begin
			integ_sum = '0;
		end else begin
			err = longint'(tgt) - longint'(meas);
			if (gains.ki != 0) begin
				sum = longint'(integ_sum) + err;
				if (sum > SUM_HI) sum = SUM_HI;
				if (sum < SUM_LO) sum = SUM_LO;
				integ_sum = sum[SUM_W-1:0];
			end else begin
				integ_sum = '0;
			end
			acc = longint'($signed(gains.kp)) * err
				+ longint'($signed(gains.ki)) * longint'(integ_sum)
				- longint'($signed(gains.kd)) * (longint'(meas) - longint'(last_measured));
			acc = acc >>> GAIN_FRAC_BITS;
			if (acc > 32767) begin
				acc = 32767;
				res.limited = 1'b1;
			end
			if (acc < -32768) begin
				acc = -32768;
				res.limited = 1'b1;
			end
			if (acc > 0) acc = acc + longint'(gains.out_offset);
			if (acc < 0) acc = acc - longint'(gains.out_offset);
			if (acc > longint'($signed(gains.upper_limit))) begin
				acc = longint'($signed(gains.upper_limit));
				res.limited = 1'b1;
			end
			if (acc < longint'($signed(gains.lower_limit))) begin
				acc = longint'($signed(gains.lower_limit));
				res.limited = 1'b1;
			end
			res.drive = acc[15:0];
			last_measured = meas;
		end
	endfunction

	// Predicts on every accepted input word and checks every accepted result word.
	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		if (out_valid && out_ready) begin
			got.drive = drive;
			got.limited = limited;
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected result word drive %0d limited %0b",
					$time, got.drive, got.limited);
				mismatch_count++;
			end else begin
				want = pending_drives.pop_front();
				if (got.drive !== want.drive) begin
					$display("%0t: drive expected %0d got %0d", $time, want.drive, got.drive);
					mismatch_count++;
				end
				if (got.limited !== want.limited) begin
					$display("%0t: limited expected %0b got %0b",
						$time, want.limited, got.limited);
					mismatch_count++;
				end
			end
		end
		if (in_valid && in_ready) begin
			predict_tick(mode, target, measured, want);
			pending_drives.push_back(want);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Result side stalls on its own pattern, switching between styles now and then.
	always @(negedge clk) begin
		if (ready_count == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_count <= $urandom_range(8, 80);
		end else begin
			ready_count <= ready_count - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (ready_count[1:0] != 2'd0);
		endcase
	end

	// All stimulus tasks start and end at a falling edge.
	task automatic write_reg(input reg_idx_t idx, input int value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		case (idx)
			REG_KP: gains.kp = value[15:0];
			REG_KI: gains.ki = value[15:0];
			REG_KD: gains.kd = value[15:0];
			REG_OUT_OFFSET: gains.out_offset = value[14:0];
			REG_UPPER_LIMIT: gains.upper_limit = value[15:0];
			REG_LOWER_LIMIT: gains.lower_limit = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic write_all(input int kp, input int ki, input int kd, input int ofs,
		input int upper, input int lower);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_OUT_OFFSET, ofs);
		write_reg(REG_UPPER_LIMIT, upper);
		write_reg(REG_LOWER_LIMIT, lower);
	endtask

	task automatic send_word(input logic clr, input logic signed [15:0] tgt,
		input logic signed [15:0] meas);
		mode = clr;
		target = tgt;
		measured = meas;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid = 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3))
				@(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end
	endtask

	// Holds the sender until every expected result word has come back.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_drives.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3, 4: return 16'($urandom_range(0, 400) - 200);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(1'b0, 16'sh7fff, 16'sh8000);
		send_word(1'b1, 16'sh7fff, 16'sh8000);
		send_word(1'b0, 16'sh8000, 16'sh7fff);
		wait_drained();
	endtask

	task automatic test_proportional_extremes();
		write_all(32767, 0, 0, 0, 32767, -32768);
		send_word(1'b0, 16'sh7fff, 16'sh8000);
		send_word(1'b0, 16'sh8000, 16'sh7fff);
		wait_drained();
		write_reg(REG_KP, -32768);
		send_word(1'b0, 16'sh7fff, 16'sh8000);
		send_word(1'b0, 16'sh8000, 16'sh7fff);
		wait_drained();
		write_reg(REG_KP, 256);
		send_word(1'b0, 16'sd100, 16'sd40);
		wait_drained();
	endtask

	task automatic test_integral_and_clear();
		write_all(0, 256, 0, 0, 32767, -32768);
		send_word(1'b0, 16'sd10, 16'sd0);
		send_word(1'b0, 16'sd10, 16'sd0);
		send_word(1'b0, 16'sd10, 16'sd0);
		// A clear drops the integral but must keep the previous measurement.
		send_word(1'b1, 16'sh8000, 16'sh7fff);
		send_word(1'b0, 16'sd10, 16'sd0);
		wait_drained();
		write_all(0, 0, -32768, 0, 32767, -32768);
		send_word(1'b0, 16'sd0, 16'sh7fff);
		send_word(1'b0, 16'sd0, 16'sh8000);
		wait_drained();
	endtask

	task automatic test_offset_and_limits();
		write_all(256, 0, 0, 32767, 32767, -32768);
		send_word(1'b0, 16'sd1, 16'sd0);
		send_word(1'b0, -16'sd1, 16'sd0);
		send_word(1'b0, 16'sd0, 16'sd0);
		wait_drained();
		// Crossed limits: the lower limit wins.
		write_all(256, 0, 0, 0, -100, 100);
		send_word(1'b0, 16'sd500, 16'sd0);
		send_word(1'b0, -16'sd500, 16'sd0);
		wait_drained();
	endtask

	task automatic apply_setting(input int phase);
		case (phase)
			0: write_all(256, 1, 0, 0, 32767, -32768);
			1: write_all(-32768, -32768, -32768, 32767, 32767, -32768);
			2: write_all(32767, 32767, 32767, 0, 1000, -1000);
			3: write_all(512, 16, 128, 50, -200, 200);
			4: write_all(300, 0, -300, 10, 32767, -32768);
			5: write_all(16, 1, 64, 0, 32767, -32768);
			6: write_all(32767, -1, -32768, 32767, -32768, 32767);
			default: write_all(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
				int'($urandom_range(0, 65535)), int'($urandom_range(0, 32767)),
				int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
		endcase
	endtask

	task automatic test_random_phases();
		int sent;
		int len;
		logic signed [15:0] tgt;
		logic signed [15:0] meas;
		logic signed [15:0] step;
		for (int phase = 0; phase < 12; phase++) begin
			apply_setting(phase);
			sent = 0;
			while (sent < 100) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						// Steady error long enough to wind the integral up.
						tgt = pick_sample();
						meas = pick_sample();
						len = $urandom_range(4, 40);
						for (int k = 0; k < len; k++)
							send_word(1'b0, tgt, meas + 16'($urandom_range(0, 6) - 3));
						sent += len;
					end
					4, 5, 6: begin
						len = $urandom_range(1, 10);
						for (int k = 0; k < len; k++)
							send_word(1'($urandom_range(0, 1) & ($urandom_range(0, 7) == 0)),
								16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
						sent += len;
					end
					7: begin
						send_word(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
						sent++;
					end
					default: begin
						tgt = pick_sample();
						meas = pick_sample();
						step = 16'($urandom_range(0, 2000) - 1000);
						len = $urandom_range(5, 30);
						for (int k = 0; k < len; k++) begin
							send_word(1'b0, tgt, meas);
							meas = meas + step;
						end
						sent += len;
					end
				endcase
				if (phase == 5 && sent >= 50 && sent < 60) wait_drained();
			end
			wait_drained();
		end
	endtask

	initial begin
		gains.kp = '0;
		gains.ki = '0;
		gains.kd = '0;
		gains.out_offset = '0;
		gains.upper_limit = 16'sh7fff;
		gains.lower_limit = 16'sh8000;
		integ_sum = '0;
		last_measured = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_proportional_extremes();
		test_integral_and_clear();
		test_offset_and_limits();
		test_random_phases();
		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && pending_drives.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
